>>> hdl/admm_pkg.sv
// admm_pkg: shared types, fixed-point constants, operand codes and the
// microprogram of the two-node consensus dimming solver.
// Used by admm_two_node_dimming_solver_top; depends on nothing else.
`default_nettype none

package admm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int CFG_W     = 31;
  localparam int DIV_W     = DW + FRAC_BITS;
  localparam int DIV_CW    = $clog2(DIV_W + 1);

  localparam longint ONE_L   = longint'(1) << FRAC_BITS;
  localparam longint MAXD_L  = 100 * ONE_L;
  localparam longint TOL_L   = (ONE_L + 500) / 1000;
  localparam longint RHO_L   = (7 * ONE_L + 50) / 100;
  localparam longint Q_L     = (ONE_L + 5) / 10;
  localparam longint RHOH_L  = (7 * ONE_L + 100) / 200;
  localparam longint RHOQ_L  = RHO_L + Q_L;

  localparam logic [DW-1:0] C_ONE    = DW'(ONE_L);
  localparam logic [DW-1:0] C_MAXD   = DW'(MAXD_L);
  localparam logic [DW-1:0] C_TOL    = DW'(TOL_L);
  localparam logic [DW-1:0] C_NTOL   = DW'(-TOL_L);
  localparam logic [DW-1:0] C_MAXDT  = DW'(MAXD_L + TOL_L);
  localparam logic [DW-1:0] C_RHO    = DW'(RHO_L);
  localparam logic [DW-1:0] C_Q      = DW'(Q_L);
  localparam logic [DW-1:0] C_RHOH   = DW'(RHOH_L);
  localparam logic [DW-1:0] C_RHOQ   = DW'(RHOQ_L);
  localparam logic [DW-1:0] C_MAXINT = 32'h7fff_ffff;
  localparam logic [DW-1:0] C_MININT = 32'h8000_0000;
  localparam logic signed [63:0] MUL_RND = 64'sd1 <<< (FRAC_BITS - 1);

  // configuration register indexes
  localparam logic [1:0] CFG_LOWER   = 2'd0;
  localparam logic [1:0] CFG_AMBIENT = 2'd1;
  localparam logic [1:0] CFG_GAIN0   = 2'd2;
  localparam logic [1:0] CFG_GAIN1   = 2'd3;

  // solution case codes
  localparam logic [7:0] SOL_UNCON  = 8'd0;
  localparam logic [7:0] SOL_LIN    = 8'd1;
  localparam logic [7:0] SOL_UPPER  = 8'd2;
  localparam logic [7:0] SOL_LOWER  = 8'd3;
  localparam logic [7:0] SOL_LIN_UP = 8'd4;
  localparam logic [7:0] SOL_LIN_LO = 8'd5;
  localparam logic [7:0] SOL_NONE   = 8'd6;
  localparam logic [2:0] SOL_INVALID = 3'd7;

  typedef logic [5:0] opd_t;
  typedef logic [7:0] pc_t;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_DIV, OP_AVG, OP_MOV,
    OP_LT, OP_EQ, OP_BT, OP_BF, OP_JMP, OP_CALL, OP_RET,
    OP_SETK, OP_SELK, OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    opd_t dst;
    opd_t srca;
    opd_t srcb;
    pc_t  imm;
  } instr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_DIV, ST_DONE
  } state_t;

  // named values visible as operands
  typedef struct packed {
    logic [DW-1:0] dual0;
    logic [DW-1:0] dual1;
    logic [DW-1:0] dx0;
    logic [DW-1:0] dx1;
    logic [DW-1:0] avg0;
    logic [DW-1:0] avg1;
    logic [DW-1:0] lb;
    logic [DW-1:0] amb;
    logic [DW-1:0] k0;
    logic [DW-1:0] k1;
    logic [DW-1:0] nj0;
    logic [DW-1:0] nj1;
  } st_vals_t;

  // operand codes: 0..15 scratch file, the rest named values and constants
  localparam opd_t R_T0 = 6'd0,  R_T1 = 6'd1,  R_T2 = 6'd2,  R_T3 = 6'd3;
  localparam opd_t R_T4 = 6'd4,  R_T5 = 6'd5,  R_T6 = 6'd6,  R_T7 = 6'd7;
  localparam opd_t R_T8 = 6'd8,  R_T9 = 6'd9,  R_T10 = 6'd10, R_T11 = 6'd11;
  localparam opd_t R_T12 = 6'd12, R_T13 = 6'd13, R_T14 = 6'd14, R_T15 = 6'd15;
  localparam opd_t R_DUAL0 = 6'd16, R_DUAL1 = 6'd17, R_DX0 = 6'd18, R_DX1 = 6'd19;
  localparam opd_t R_AVG0 = 6'd20, R_AVG1 = 6'd21, R_LB = 6'd22, R_AMB = 6'd23;
  localparam opd_t R_K0 = 6'd24, R_K1 = 6'd25, R_NJ0 = 6'd26, R_NJ1 = 6'd27;
  localparam opd_t R_ONE = 6'd28, R_MAXD = 6'd29, R_TOL = 6'd30, R_RHO = 6'd31;
  localparam opd_t R_Q = 6'd32, R_RHOH = 6'd33, R_RHOQ = 6'd34, R_ZERO = 6'd35;
  localparam opd_t R_MAXINT = 6'd36, R_NTOL = 6'd37, R_MAXDT = 6'd38;

  localparam pc_t L_INF   = 8'd36;
  localparam pc_t L_SKIP1 = 8'd79;
  localparam pc_t L_FIN   = 8'd99;
  localparam pc_t L_CONS  = 8'd102;
  localparam pc_t L_RET   = 8'd134;

  function automatic logic is_temp(input opd_t c);
    return c[5:4] == 2'b00;
  endfunction

  function automatic logic [DW-1:0] spec_val(input opd_t c, input st_vals_t v);
    logic [DW-1:0] r;
    case (c)
      R_DUAL0:  r = v.dual0;
      R_DUAL1:  r = v.dual1;
      R_DX0:    r = v.dx0;
      R_DX1:    r = v.dx1;
      R_AVG0:   r = v.avg0;
      R_AVG1:   r = v.avg1;
      R_LB:     r = v.lb;
      R_AMB:    r = v.amb;
      R_K0:     r = v.k0;
      R_K1:     r = v.k1;
      R_NJ0:    r = v.nj0;
      R_NJ1:    r = v.nj1;
      R_ONE:    r = C_ONE;
      R_MAXD:   r = C_MAXD;
      R_TOL:    r = C_TOL;
      R_RHO:    r = C_RHO;
      R_Q:      r = C_Q;
      R_RHOH:   r = C_RHOH;
      R_RHOQ:   r = C_RHOQ;
      R_MAXINT: r = C_MAXINT;
      R_NTOL:   r = C_NTOL;
      R_MAXDT:  r = C_MAXDT;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [DW-1:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return C_MAXINT;
    end else if (v < -64'sd2147483648) begin
      return C_MININT;
    end
    return v[DW-1:0];
  endfunction

  function automatic instr_t mk(input op_t op, input opd_t d, input opd_t a,
                                input opd_t b, input pc_t imm);
    instr_t r;
    r.op = op; r.dst = d; r.srca = a; r.srcb = b; r.imm = imm;
    return r;
  endfunction

  // microprogram; feasibility test and candidate update live in a subroutine
  function automatic instr_t prog(input pc_t pc);
    instr_t r;
    case (pc)
      8'd0:   r = mk(OP_AVG,  R_AVG0,  R_DX0,   R_NJ1,  8'd0);
      8'd1:   r = mk(OP_AVG,  R_AVG1,  R_DX1,   R_NJ0,  8'd0);
      8'd2:   r = mk(OP_SUB,  R_T0,    R_DX0,   R_AVG0, 8'd0);
      8'd3:   r = mk(OP_MUL,  R_T0,    R_RHO,   R_T0,   8'd0);
      8'd4:   r = mk(OP_ADD,  R_DUAL0, R_DUAL0, R_T0,   8'd0);
      8'd5:   r = mk(OP_SUB,  R_T0,    R_DX1,   R_AVG1, 8'd0);
      8'd6:   r = mk(OP_MUL,  R_T0,    R_RHO,   R_T0,   8'd0);
      8'd7:   r = mk(OP_ADD,  R_DUAL1, R_DUAL1, R_T0,   8'd0);
      8'd8:   r = mk(OP_ADD,  R_T1,    R_ONE,   R_DUAL0, 8'd0);
      8'd9:   r = mk(OP_MUL,  R_T0,    R_RHO,   R_AVG0, 8'd0);
      8'd10:  r = mk(OP_SUB,  R_T1,    R_T1,    R_T0,   8'd0);
      8'd11:  r = mk(OP_MUL,  R_T0,    R_AVG1,  R_RHO,  8'd0);
      8'd12:  r = mk(OP_SUB,  R_T2,    R_DUAL1, R_T0,   8'd0);
      8'd13:  r = mk(OP_NEG,  R_T3,    R_T2,    R_ZERO, 8'd0);
      8'd14:  r = mk(OP_SUB,  R_T4,    R_LB,    R_AMB,  8'd0);
      8'd15:  r = mk(OP_NEG,  R_T0,    R_T1,    R_ZERO, 8'd0);
      8'd16:  r = mk(OP_DIV,  R_T5,    R_T0,    R_RHOQ, 8'd0);
      8'd17:  r = mk(OP_DIV,  R_T6,    R_T3,    R_RHO,  8'd0);
      8'd18:  r = mk(OP_MOV,  R_T7,    R_T5,    R_ZERO, 8'd0);
      8'd19:  r = mk(OP_MOV,  R_T8,    R_T6,    R_ZERO, 8'd0);
      8'd20:  r = mk(OP_MOV,  R_T11,   R_T5,    R_ZERO, 8'd0);
      8'd21:  r = mk(OP_MOV,  R_T12,   R_T6,    R_ZERO, 8'd0);
      8'd22:  r = mk(OP_LT,   R_ZERO,  R_T7,    R_NTOL, 8'd0);
      8'd23:  r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_INF);
      8'd24:  r = mk(OP_LT,   R_ZERO,  R_MAXDT, R_T7,   8'd0);
      8'd25:  r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_INF);
      8'd26:  r = mk(OP_MUL,  R_T13,   R_T7,    R_K0,   8'd0);
      8'd27:  r = mk(OP_MUL,  R_T14,   R_T8,    R_K1,   8'd0);
      8'd28:  r = mk(OP_ADD,  R_T13,   R_T13,   R_T14,  8'd0);
      8'd29:  r = mk(OP_SUB,  R_T14,   R_LB,    R_AMB,  8'd0);
      8'd30:  r = mk(OP_SUB,  R_T14,   R_T14,   R_TOL,  8'd0);
      8'd31:  r = mk(OP_LT,   R_ZERO,  R_T13,   R_T14,  8'd0);
      8'd32:  r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_INF);
      8'd33:  r = mk(OP_SETK, R_ZERO,  R_ZERO,  R_ZERO, SOL_UNCON);
      8'd34:  r = mk(OP_SELK, R_ZERO,  R_ZERO,  R_ZERO, 8'd0);
      8'd35:  r = mk(OP_JMP,  R_ZERO,  R_ZERO,  R_ZERO, L_FIN);
      // unconstrained point infeasible: search boundary candidates
      8'd36:  r = mk(OP_MOV,  R_T10,   R_MAXINT, R_ZERO, 8'd0);
      8'd37:  r = mk(OP_SETK, R_ZERO,  R_ZERO,  R_ZERO, SOL_NONE);
      8'd38:  r = mk(OP_SELK, R_ZERO,  R_ZERO,  R_ZERO, 8'd0);
      8'd39:  r = mk(OP_MUL,  R_T0,    R_K1,    R_K1,   8'd0);
      8'd40:  r = mk(OP_MUL,  R_T0,    R_T0,    R_T1,   8'd0);
      8'd41:  r = mk(OP_MUL,  R_T9,    R_K0,    R_RHO,  8'd0);
      8'd42:  r = mk(OP_SUB,  R_T13,   R_AMB,   R_LB,   8'd0);
      8'd43:  r = mk(OP_MUL,  R_T9,    R_T9,    R_T13,  8'd0);
      8'd44:  r = mk(OP_ADD,  R_T0,    R_T0,    R_T9,   8'd0);
      8'd45:  r = mk(OP_MUL,  R_T9,    R_K0,    R_K1,   8'd0);
      8'd46:  r = mk(OP_MUL,  R_T9,    R_T9,    R_T3,   8'd0);
      8'd47:  r = mk(OP_ADD,  R_T0,    R_T0,    R_T9,   8'd0);
      8'd48:  r = mk(OP_MUL,  R_T9,    R_K1,    R_K1,   8'd0);
      8'd49:  r = mk(OP_MUL,  R_T9,    R_T9,    R_RHOQ, 8'd0);
      8'd50:  r = mk(OP_MUL,  R_T13,   R_K0,    R_K0,   8'd0);
      8'd51:  r = mk(OP_MUL,  R_T13,   R_T13,   R_RHO,  8'd0);
      8'd52:  r = mk(OP_ADD,  R_T15,   R_T9,    R_T13,  8'd0);
      8'd53:  r = mk(OP_EQ,   R_ZERO,  R_T15,   R_ZERO, 8'd0);
      8'd54:  r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_SKIP1);
      8'd55:  r = mk(OP_EQ,   R_ZERO,  R_K1,    R_ZERO, 8'd0);
      8'd56:  r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_SKIP1);
      8'd57:  r = mk(OP_DIV,  R_T0,    R_T0,    R_T15,  8'd0);
      8'd58:  r = mk(OP_NEG,  R_T7,    R_T0,    R_ZERO, 8'd0);
      8'd59:  r = mk(OP_MUL,  R_T0,    R_K1,    R_T2,   8'd0);
      8'd60:  r = mk(OP_DIV,  R_T0,    R_T0,    R_RHO,  8'd0);
      8'd61:  r = mk(OP_ADD,  R_T0,    R_T4,    R_T0,   8'd0);
      8'd62:  r = mk(OP_MUL,  R_T9,    R_K1,    R_T1,   8'd0);
      8'd63:  r = mk(OP_DIV,  R_T9,    R_T9,    R_RHOQ, 8'd0);
      8'd64:  r = mk(OP_ADD,  R_T0,    R_T0,    R_T9,   8'd0);
      8'd65:  r = mk(OP_MUL,  R_T9,    R_K0,    R_K0,   8'd0);
      8'd66:  r = mk(OP_DIV,  R_T9,    R_T9,    R_RHOQ, 8'd0);
      8'd67:  r = mk(OP_MUL,  R_T13,   R_K1,    R_K1,   8'd0);
      8'd68:  r = mk(OP_DIV,  R_T13,   R_T13,   R_RHO,  8'd0);
      8'd69:  r = mk(OP_ADD,  R_T9,    R_T9,    R_T13,  8'd0);
      8'd70:  r = mk(OP_MUL,  R_T15,   R_RHO,   R_T9,   8'd0);
      8'd71:  r = mk(OP_EQ,   R_ZERO,  R_T15,   R_ZERO, 8'd0);
      8'd72:  r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_SKIP1);
      8'd73:  r = mk(OP_MUL,  R_T0,    R_K1,    R_T0,   8'd0);
      8'd74:  r = mk(OP_DIV,  R_T0,    R_T0,    R_T15,  8'd0);
      8'd75:  r = mk(OP_DIV,  R_T9,    R_T2,    R_RHO,  8'd0);
      8'd76:  r = mk(OP_SUB,  R_T8,    R_T0,    R_T9,   8'd0);
      8'd77:  r = mk(OP_SETK, R_ZERO,  R_ZERO,  R_ZERO, SOL_LIN);
      8'd78:  r = mk(OP_CALL, R_ZERO,  R_ZERO,  R_ZERO, L_CONS);
      8'd79:  r = mk(OP_MOV,  R_T7,    R_MAXD,  R_ZERO, 8'd0);
      8'd80:  r = mk(OP_MOV,  R_T8,    R_T6,    R_ZERO, 8'd0);
      8'd81:  r = mk(OP_SETK, R_ZERO,  R_ZERO,  R_ZERO, SOL_UPPER);
      8'd82:  r = mk(OP_CALL, R_ZERO,  R_ZERO,  R_ZERO, L_CONS);
      8'd83:  r = mk(OP_MOV,  R_T7,    R_ZERO,  R_ZERO, 8'd0);
      8'd84:  r = mk(OP_MOV,  R_T8,    R_T6,    R_ZERO, 8'd0);
      8'd85:  r = mk(OP_SETK, R_ZERO,  R_ZERO,  R_ZERO, SOL_LOWER);
      8'd86:  r = mk(OP_CALL, R_ZERO,  R_ZERO,  R_ZERO, L_CONS);
      8'd87:  r = mk(OP_EQ,   R_ZERO,  R_K1,    R_ZERO, 8'd0);
      8'd88:  r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_FIN);
      8'd89:  r = mk(OP_MUL,  R_T0,    R_MAXD,  R_K0,   8'd0);
      8'd90:  r = mk(OP_SUB,  R_T0,    R_T4,    R_T0,   8'd0);
      8'd91:  r = mk(OP_DIV,  R_T8,    R_T0,    R_K1,   8'd0);
      8'd92:  r = mk(OP_MOV,  R_T7,    R_MAXD,  R_ZERO, 8'd0);
      8'd93:  r = mk(OP_SETK, R_ZERO,  R_ZERO,  R_ZERO, SOL_LIN_UP);
      8'd94:  r = mk(OP_CALL, R_ZERO,  R_ZERO,  R_ZERO, L_CONS);
      8'd95:  r = mk(OP_DIV,  R_T8,    R_T4,    R_K1,   8'd0);
      8'd96:  r = mk(OP_MOV,  R_T7,    R_ZERO,  R_ZERO, 8'd0);
      8'd97:  r = mk(OP_SETK, R_ZERO,  R_ZERO,  R_ZERO, SOL_LIN_LO);
      8'd98:  r = mk(OP_CALL, R_ZERO,  R_ZERO,  R_ZERO, L_CONS);
      8'd99:  r = mk(OP_MOV,  R_DX0,   R_T11,   R_ZERO, 8'd0);
      8'd100: r = mk(OP_MOV,  R_DX1,   R_T12,   R_ZERO, 8'd0);
      8'd101: r = mk(OP_DONE, R_ZERO,  R_ZERO,  R_ZERO, 8'd0);
      // candidate subroutine: x in t7/t8, best cost t10, best point t11/t12
      8'd102: r = mk(OP_LT,   R_ZERO,  R_T7,    R_NTOL, 8'd0);
      8'd103: r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_RET);
      8'd104: r = mk(OP_LT,   R_ZERO,  R_MAXDT, R_T7,   8'd0);
      8'd105: r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_RET);
      8'd106: r = mk(OP_MUL,  R_T13,   R_T7,    R_K0,   8'd0);
      8'd107: r = mk(OP_MUL,  R_T14,   R_T8,    R_K1,   8'd0);
      8'd108: r = mk(OP_ADD,  R_T13,   R_T13,   R_T14,  8'd0);
      8'd109: r = mk(OP_SUB,  R_T14,   R_LB,    R_AMB,  8'd0);
      8'd110: r = mk(OP_SUB,  R_T14,   R_T14,   R_TOL,  8'd0);
      8'd111: r = mk(OP_LT,   R_ZERO,  R_T13,   R_T14,  8'd0);
      8'd112: r = mk(OP_BT,   R_ZERO,  R_ZERO,  R_ZERO, L_RET);
      8'd113: r = mk(OP_SUB,  R_T13,   R_T7,    R_AVG0, 8'd0);
      8'd114: r = mk(OP_SUB,  R_T14,   R_T8,    R_AVG1, 8'd0);
      8'd115: r = mk(OP_MUL,  R_T9,    R_ONE,   R_T7,   8'd0);
      8'd116: r = mk(OP_MUL,  R_T0,    R_DUAL0, R_T13,  8'd0);
      8'd117: r = mk(OP_ADD,  R_T9,    R_T9,    R_T0,   8'd0);
      8'd118: r = mk(OP_MUL,  R_T0,    R_DUAL1, R_T14,  8'd0);
      8'd119: r = mk(OP_ADD,  R_T9,    R_T9,    R_T0,   8'd0);
      8'd120: r = mk(OP_MUL,  R_T13,   R_T13,   R_T13,  8'd0);
      8'd121: r = mk(OP_MUL,  R_T14,   R_T14,   R_T14,  8'd0);
      8'd122: r = mk(OP_ADD,  R_T13,   R_T13,   R_T14,  8'd0);
      8'd123: r = mk(OP_MUL,  R_T13,   R_RHOH,  R_T13,  8'd0);
      8'd124: r = mk(OP_ADD,  R_T9,    R_T9,    R_T13,  8'd0);
      8'd125: r = mk(OP_MUL,  R_T0,    R_T7,    R_T7,   8'd0);
      8'd126: r = mk(OP_MUL,  R_T0,    R_T0,    R_Q,    8'd0);
      8'd127: r = mk(OP_ADD,  R_T9,    R_T9,    R_T0,   8'd0);
      8'd128: r = mk(OP_LT,   R_ZERO,  R_T9,    R_T10,  8'd0);
      8'd129: r = mk(OP_BF,   R_ZERO,  R_ZERO,  R_ZERO, L_RET);
      8'd130: r = mk(OP_MOV,  R_T10,   R_T9,    R_ZERO, 8'd0);
      8'd131: r = mk(OP_MOV,  R_T11,   R_T7,    R_ZERO, 8'd0);
      8'd132: r = mk(OP_MOV,  R_T12,   R_T8,    R_ZERO, 8'd0);
      8'd133: r = mk(OP_SELK, R_ZERO,  R_ZERO,  R_ZERO, 8'd0);
      8'd134: r = mk(OP_RET,  R_ZERO,  R_ZERO,  R_ZERO, 8'd0);
      default: r = mk(OP_DONE, R_ZERO, R_ZERO,  R_ZERO, 8'd0);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/admm_two_node_dimming_solver_top.sv
// admm_two_node_dimming_solver_top: one consensus iteration per request,
// run by a microcoded sequencer over one shared add/multiply/divide unit.
// Depends on admm_pkg.
//
//   channel | signals                                  | direction
//   in      | in_valid, in_ready, in_neighbor_*        | request in
//   out     | out_valid, out_ready, out_duty_*, ...    | result out
//   cfg     | cfg_we, cfg_index, cfg_wdata             | register write
//
// each microinstruction is fetched, then executed; a divide is restoring
// (one quotient bit per cycle); the run time of a request depends on how
// many boundary candidates pass the feasibility test.
// in_ready is high only in idle; a stalled result waits in the output
// register while the next request is already computed.
// reset is synchronous; the scratch file needs no clearing.
`default_nettype none

module admm_two_node_dimming_solver_top (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire signed [admm_pkg::DW-1:0]         in_neighbor_self_duty,
  input  wire signed [admm_pkg::DW-1:0]         in_neighbor_view_of_ours,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [admm_pkg::DW-1:0]        out_duty_own,
  output logic signed [admm_pkg::DW-1:0]        out_duty_neighbor_est,
  output logic signed [admm_pkg::DW-1:0]        out_average_own,
  output logic signed [admm_pkg::DW-1:0]        out_average_neighbor,
  output logic [2:0]                            out_solution_case,
  input  wire                                   cfg_we,
  input  wire [1:0]                             cfg_index,
  input  wire [admm_pkg::CFG_W-1:0]             cfg_wdata
);

  localparam int DW = admm_pkg::DW;
  localparam int DIV_W = admm_pkg::DIV_W;

  admm_pkg::state_t state_r, state_nxt;
  admm_pkg::pc_t    pc_r, pc_nxt, ret_r, ret_nxt;
  admm_pkg::instr_t ir_r, fetch_ins;
  logic             flag_r, flag_nxt;
  logic [2:0]       cand_r, cand_nxt, sel_r, sel_nxt;

  logic [DW-1:0] dual0_r, dual1_r, dx0_r, dx1_r, avg0_r, avg1_r;
  logic [DW-1:0] nj0_r, nj1_r;
  logic [admm_pkg::CFG_W-1:0] lb_r, amb_r, k0_r, k1_r;

  logic [DW-1:0] rf_mem [16];
  logic [DW-1:0] rda_r, rdb_r;

  logic signed [63:0] prod_r, prod_nxt;
  logic [DW-1:0]      div_rem_r, div_rem_nxt;
  logic [DIV_W-1:0]   div_q_r, div_q_nxt;
  logic [DW-1:0]      div_d_r, div_d_nxt;
  logic               div_neg_r, div_neg_nxt;
  logic [admm_pkg::DIV_CW-1:0] div_cnt_r, div_cnt_nxt;

  logic          out_valid_r;
  logic [DW-1:0] o_dx0_r, o_dx1_r, o_avg0_r, o_avg1_r;
  logic [2:0]    o_sel_r;

  admm_pkg::st_vals_t vals;
  logic [DW-1:0]      a_v, b_v, wr_val;
  logic               wr_en, accept, load_out;
  logic signed [32:0] sum33, dif33, neg33;
  logic signed [63:0] mul_rnd;
  logic [32:0]        rem_sh;
  logic               div_ge;
  logic [DW-1:0]      abs_a, abs_b;

  assign accept = in_valid && in_ready;

  always_comb begin
    vals.dual0 = dual0_r;
    vals.dual1 = dual1_r;
    vals.dx0   = dx0_r;
    vals.dx1   = dx1_r;
    vals.avg0  = avg0_r;
    vals.avg1  = avg1_r;
    vals.lb    = {1'b0, lb_r};
    vals.amb   = {1'b0, amb_r};
    vals.k0    = {1'b0, k0_r};
    vals.k1    = {1'b0, k1_r};
    vals.nj0   = nj0_r;
    vals.nj1   = nj1_r;
  end

  assign fetch_ins = admm_pkg::prog(pc_r);
  assign a_v = admm_pkg::is_temp(ir_r.srca) ? rda_r : admm_pkg::spec_val(ir_r.srca, vals);
  assign b_v = admm_pkg::is_temp(ir_r.srcb) ? rdb_r : admm_pkg::spec_val(ir_r.srcb, vals);

  assign sum33   = $signed({a_v[DW-1], a_v}) + $signed({b_v[DW-1], b_v});
  assign dif33   = $signed({a_v[DW-1], a_v}) - $signed({b_v[DW-1], b_v});
  assign neg33   = 33'sd0 - $signed({a_v[DW-1], a_v});
  assign mul_rnd = prod_r + admm_pkg::MUL_RND;
  assign abs_a   = a_v[DW-1] ? DW'(-a_v) : a_v;
  assign abs_b   = b_v[DW-1] ? DW'(-b_v) : b_v;
  // restoring divider step: one quotient bit per cycle
  assign rem_sh  = {div_rem_r, div_q_r[DIV_W-1]};
  assign div_ge  = rem_sh >= {1'b0, div_d_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      admm_pkg::ST_IDLE:  if (in_valid) state_nxt = admm_pkg::ST_FETCH;
      admm_pkg::ST_FETCH: state_nxt = admm_pkg::ST_EXEC;
      admm_pkg::ST_EXEC: begin
        case (ir_r.op)
          admm_pkg::OP_MUL:  state_nxt = admm_pkg::ST_MUL;
          admm_pkg::OP_DIV:  state_nxt = (b_v == '0) ? admm_pkg::ST_FETCH : admm_pkg::ST_DIV;
          admm_pkg::OP_DONE: state_nxt = admm_pkg::ST_DONE;
          default:           state_nxt = admm_pkg::ST_FETCH;
        endcase
      end
      admm_pkg::ST_MUL:   state_nxt = admm_pkg::ST_FETCH;
      admm_pkg::ST_DIV:   if (div_cnt_r == '0) state_nxt = admm_pkg::ST_FETCH;
      admm_pkg::ST_DONE:  if (!out_valid_r || out_ready) state_nxt = admm_pkg::ST_IDLE;
      default:            state_nxt = admm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state_r == admm_pkg::ST_IDLE);
    load_out = (state_r == admm_pkg::ST_DONE) && (!out_valid_r || out_ready);
  end

  // datapath and sequencing
  always_comb begin
    pc_nxt      = pc_r;
    ret_nxt     = ret_r;
    flag_nxt    = flag_r;
    cand_nxt    = cand_r;
    sel_nxt     = sel_r;
    prod_nxt    = prod_r;
    div_rem_nxt = div_rem_r;
    div_q_nxt   = div_q_r;
    div_d_nxt   = div_d_r;
    div_neg_nxt = div_neg_r;
    div_cnt_nxt = div_cnt_r;
    wr_en       = 1'b0;
    wr_val      = '0;
    case (state_r)
      admm_pkg::ST_FETCH: pc_nxt = pc_r + 8'd1;
      admm_pkg::ST_EXEC: begin
        case (ir_r.op)
          admm_pkg::OP_ADD: begin
            wr_en = 1'b1; wr_val = admm_pkg::sat64(64'(sum33));
          end
          admm_pkg::OP_SUB: begin
            wr_en = 1'b1; wr_val = admm_pkg::sat64(64'(dif33));
          end
          admm_pkg::OP_NEG: begin
            wr_en = 1'b1; wr_val = admm_pkg::sat64(64'(neg33));
          end
          admm_pkg::OP_AVG: begin
            wr_en = 1'b1; wr_val = sum33[DW:1];
          end
          admm_pkg::OP_MOV: begin
            wr_en = 1'b1; wr_val = a_v;
          end
          admm_pkg::OP_MUL: prod_nxt = $signed(a_v) * $signed(b_v);
          admm_pkg::OP_DIV: begin
            if (b_v == '0) begin
              wr_en = 1'b1; wr_val = '0;
            end else begin
              div_q_nxt   = {abs_a, {admm_pkg::FRAC_BITS{1'b0}}};
              div_rem_nxt = '0;
              div_d_nxt   = abs_b;
              div_neg_nxt = a_v[DW-1] ^ b_v[DW-1];
              div_cnt_nxt = admm_pkg::DIV_CW'(DIV_W);
            end
          end
          admm_pkg::OP_LT:   flag_nxt = $signed(a_v) < $signed(b_v);
          admm_pkg::OP_EQ:   flag_nxt = (a_v == b_v);
          admm_pkg::OP_BT:   if (flag_r) pc_nxt = ir_r.imm;
          admm_pkg::OP_BF:   if (!flag_r) pc_nxt = ir_r.imm;
          admm_pkg::OP_JMP:  pc_nxt = ir_r.imm;
          admm_pkg::OP_CALL: begin
            ret_nxt = pc_r; pc_nxt = ir_r.imm;
          end
          admm_pkg::OP_RET:  pc_nxt = ret_r;
          admm_pkg::OP_SETK: cand_nxt = ir_r.imm[2:0];
          admm_pkg::OP_SELK: sel_nxt = cand_r;
          admm_pkg::OP_DONE: pc_nxt = '0;
          default:           pc_nxt = pc_r;
        endcase
      end
      admm_pkg::ST_MUL: begin
        wr_en  = 1'b1;
        wr_val = admm_pkg::sat64(mul_rnd >>> admm_pkg::FRAC_BITS);
      end
      admm_pkg::ST_DIV: begin
        if (div_cnt_r == '0) begin
          wr_en = 1'b1;
          if (div_q_r[DIV_W-1:DW-1] != '0) begin
            wr_val = div_neg_r ? admm_pkg::C_MININT : admm_pkg::C_MAXINT;
          end else begin
            wr_val = div_neg_r ? DW'(-div_q_r[DW-1:0]) : div_q_r[DW-1:0];
          end
        end else begin
          // remainder stays below the divisor, so it fits in DW bits
          div_rem_nxt = div_ge ? DW'(rem_sh - {1'b0, div_d_r}) : rem_sh[DW-1:0];
          div_q_nxt   = {div_q_r[DIV_W-2:0], div_ge};
          div_cnt_nxt = div_cnt_r - admm_pkg::DIV_CW'(1);
        end
      end
      default: pc_nxt = pc_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= admm_pkg::ST_IDLE;
      pc_r        <= '0;
      ret_r       <= '0;
      flag_r      <= 1'b0;
      cand_r      <= '0;
      sel_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= accept ? '0 : pc_nxt;
      ret_r     <= ret_nxt;
      flag_r    <= flag_nxt;
      cand_r    <= cand_nxt;
      sel_r     <= sel_nxt;
      div_cnt_r <= div_cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // iteration state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dual0_r <= '0;
      dual1_r <= '0;
      dx0_r   <= '0;
      dx1_r   <= '0;
      avg0_r  <= '0;
      avg1_r  <= '0;
      lb_r    <= '0;
      amb_r   <= '0;
      k0_r    <= admm_pkg::CFG_W'(admm_pkg::ONE_L);
      k1_r    <= admm_pkg::CFG_W'(admm_pkg::ONE_L);
    end else begin
      if (wr_en) begin
        case (ir_r.dst)
          admm_pkg::R_DUAL0: dual0_r <= wr_val;
          admm_pkg::R_DUAL1: dual1_r <= wr_val;
          admm_pkg::R_DX0:   dx0_r   <= wr_val;
          admm_pkg::R_DX1:   dx1_r   <= wr_val;
          admm_pkg::R_AVG0:  avg0_r  <= wr_val;
          admm_pkg::R_AVG1:  avg1_r  <= wr_val;
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          admm_pkg::CFG_LOWER:   lb_r  <= cfg_wdata;
          admm_pkg::CFG_AMBIENT: amb_r <= cfg_wdata;
          admm_pkg::CFG_GAIN0:   k0_r  <= cfg_wdata;
          admm_pkg::CFG_GAIN1:   k1_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      nj0_r <= in_neighbor_self_duty;
      nj1_r <= in_neighbor_view_of_ours;
    end
    if (state_r == admm_pkg::ST_FETCH) begin
      ir_r <= fetch_ins;
    end
    prod_r    <= prod_nxt;
    div_rem_r <= div_rem_nxt;
    div_q_r   <= div_q_nxt;
    div_d_r   <= div_d_nxt;
    div_neg_r <= div_neg_nxt;
    if (load_out) begin
      o_dx0_r  <= dx0_r;
      o_dx1_r  <= dx1_r;
      o_avg0_r <= avg0_r;
      o_avg1_r <= avg1_r;
      o_sel_r  <= sel_r;
    end
  end

  // scratch file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en && admm_pkg::is_temp(ir_r.dst)) begin
      rf_mem[ir_r.dst[3:0]] <= wr_val;
    end
    if (state_r == admm_pkg::ST_FETCH) begin
      rda_r <= rf_mem[fetch_ins.srca[3:0]];
      rdb_r <= rf_mem[fetch_ins.srcb[3:0]];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_duty_own          = o_dx0_r;
  assign out_duty_neighbor_est = o_dx1_r;
  assign out_average_own       = o_avg0_r;
  assign out_average_neighbor  = o_avg1_r;
  assign out_solution_case     = o_sel_r;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == admm_pkg::ST_DONE))
    else $error("result appeared without finishing the program");

  a_accept_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (pc_r == '0) && (state_r == admm_pkg::ST_FETCH))
    else $error("request did not restart the program");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == admm_pkg::ST_IDLE) |-> !wr_en)
    else $error("write while idle");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == admm_pkg::ST_DIV) |-> (div_cnt_r <= admm_pkg::DIV_CW'(DIV_W)))
    else $error("divider count out of range");

  a_case_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_sel_r != admm_pkg::SOL_INVALID))
    else $error("bad solution case");
`endif

endmodule

`default_nettype wire
